### hw/rtl/pfs_pkg.sv
// Shared types and constants for the periodic frame scheduler.
package pfs_pkg;

  localparam int SlotCountDefault = 8;
  localparam logic [31:0] MinPeriodReset = 32'd10;
  localparam logic [28:0] StdIdMax = 29'h7FF;
  localparam logic [3:0] MaxBytes = 4'd8;

  localparam logic [1:0] ACT_START    = 2'd0;
  localparam logic [1:0] ACT_STOP     = 2'd1;
  localparam logic [1:0] ACT_STOP_ALL = 2'd2;
  localparam logic [1:0] ACT_TICK     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NO_JOB  = 2'd3;

  // Command as queued between the front and back parts.
  typedef struct packed {
    logic [1:0]  action;
    logic        bad_len;
    logic [28:0] frame_id;
    logic [63:0] payload;
    logic [3:0]  length;
    logic [31:0] repeat_count;
    logic [31:0] period;
    logic [31:0] now_ms;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic        is_frame;
    logic [1:0]  status;
    logic [28:0] out_id;
    logic        out_extended;
    logic [63:0] out_payload;
    logic [3:0]  out_length;
    logic        last;
  } res_t;

  // Zero the bytes at or beyond the length.
  function automatic logic [63:0] mask_payload(logic [63:0] d, logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) m[b*8 +: 8] = 8'hFF;
    end
    return d & m;
  endfunction

endpackage

### hw/rtl/pfs_front.sv
// Front part: takes input beats, checks length, clamps period, queues commands.
module pfs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             stall,
  input  logic [1:0]       action,
  input  logic [28:0]      frame_id,
  input  logic [63:0]      payload,
  input  logic [3:0]       length,
  input  logic [31:0]      repeat_count,
  input  logic [31:0]      period_ms,
  input  logic [31:0]      now_ms,
  input  logic [31:0]      min_period,
  output logic             cmd_valid,
  input  logic             cmd_take,
  output pfs_pkg::cmd_t    cmd
);

  // Two-entry queue
  pfs_pkg::cmd_t q [2];
  logic          rd_ptr, wr_ptr;
  logic [1:0]    count;
  logic          push, pop;
  pfs_pkg::cmd_t c;

  assign stall = (count == 2'd2);
  assign push = valid && !stall;
  assign pop = cmd_take;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];

  // Classify the incoming beat
  always_comb begin
    c.action = action;
    c.bad_len = (length == 4'd0) || (length > pfs_pkg::MaxBytes);
    c.frame_id = frame_id;
    c.payload = pfs_pkg::mask_payload(payload, length);
    c.length = length;
    c.repeat_count = repeat_count;
    c.period = (period_ms < min_period) ? min_period : period_ms;
    c.now_ms = now_ms;
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) !(pop && count == 2'd0))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> count == 2'd2)
    else $error("full queue changed without pop");

endmodule

### hw/rtl/pfs_back.sv
// Back part: slot table, command execution and slot-by-slot tick scan.
module pfs_back #(
  parameter int SLOT_COUNT = pfs_pkg::SlotCountDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  pfs_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output pfs_pkg::res_t res
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [SLOT_COUNT-1:0] active;
  logic [28:0] sid [SLOT_COUNT];
  logic        sext [SLOT_COUNT];
  logic [63:0] spay [SLOT_COUNT];
  logic [3:0]  slen [SLOT_COUNT];
  logic [31:0] stot [SLOT_COUNT];
  logic [31:0] ssent [SLOT_COUNT];
  logic [31:0] sper [SLOT_COUNT];
  logic [31:0] slast [SLOT_COUNT];
  logic [CW-1:0] active_jobs;

  logic [1:0]    state;
  logic [IW-1:0] idx;
  logic          pend_valid;
  pfs_pkg::res_t pend;

  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] free_after;
  logic          any_match, any_free;
  logic [IW-1:0] match_idx, free_idx;
  logic          full;
  logic          due;
  logic [31:0]   sent_inc;
  logic          done_job;
  logic          out_free;
  logic          is_last_slot;

  assign out_free = !res_valid || !res_stall;

  // Id match and free-slot search over the active vector
  always_comb begin
    any_match = 1'b0;
    match_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = active[i] && (sid[i] == cmd.frame_id);
      if (match[i] && !any_match) begin
        any_match = 1'b1;
        match_idx = IW'(i);
      end
    end
    free_after = ~active;
    if (any_match) free_after[match_idx] = 1'b1;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (free_after[i] && !any_free) begin
        any_free = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign full = (active_jobs >= CW'(SLOT_COUNT));
  assign due = active[idx] && ((ssent[idx] == 32'd0) ||
               ((cmd.now_ms - slast[idx]) >= sper[idx]));
  assign sent_inc = (ssent[idx] == 32'hFFFF_FFFF) ? ssent[idx] : ssent[idx] + 32'd1;
  assign done_job = (stot[idx] != 32'd0) && (sent_inc >= stot[idx]);
  assign is_last_slot = (idx == IW'(SLOT_COUNT - 1));
  assign cmd_take = cmd_valid && out_free &&
                    ((state == S_IDLE && cmd.action != pfs_pkg::ACT_TICK) ||
                     state == S_FLUSH);

  // Slot table storage
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid && out_free && cmd.action == pfs_pkg::ACT_START &&
        !cmd.bad_len && !full && any_free) begin
      sid[free_idx] <= cmd.frame_id;
      sext[free_idx] <= cmd.frame_id > pfs_pkg::StdIdMax;
      spay[free_idx] <= cmd.payload;
      slen[free_idx] <= cmd.length;
      stot[free_idx] <= cmd.repeat_count;
      ssent[free_idx] <= 32'd0;
      sper[free_idx] <= cmd.period;
      slast[free_idx] <= 32'd0;
    end else if (state == S_SCAN && !pend_valid && due) begin
      ssent[idx] <= sent_inc;
      slast[idx] <= cmd.now_ms;
    end
  end

  // Control, result staging and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      active_jobs <= '0;
      state <= S_IDLE;
      idx <= '0;
      pend_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && out_free) begin
            res.is_frame <= 1'b0;
            res.out_id <= '0;
            res.out_extended <= 1'b0;
            res.out_payload <= '0;
            res.out_length <= '0;
            res.last <= 1'b1;
            res.status <= pfs_pkg::ST_OK;
            case (cmd.action)
              pfs_pkg::ACT_START: begin
                res_valid <= 1'b1;
                if (cmd.bad_len) res.status <= pfs_pkg::ST_BAD_LEN;
                else if (full || !any_free) res.status <= pfs_pkg::ST_FULL;
                else begin
                  active <= (active & ~match) | (SLOT_COUNT'(1) << free_idx);
                  active_jobs <= active_jobs + CW'(!any_match);
                end
              end
              pfs_pkg::ACT_STOP: begin
                res_valid <= 1'b1;
                if (any_match) begin
                  active[match_idx] <= 1'b0;
                  active_jobs <= active_jobs - CW'(1);
                end else res.status <= pfs_pkg::ST_NO_JOB;
              end
              pfs_pkg::ACT_STOP_ALL: begin
                res_valid <= 1'b1;
                active <= '0;
                active_jobs <= '0;
              end
              default: begin
                state <= S_SCAN;
                idx <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Emit held frame once the next due one (or end) is known
          if (!pend_valid) begin
            if (due) begin
              pend_valid <= 1'b1;
              pend.is_frame <= 1'b1;
              pend.status <= pfs_pkg::ST_OK;
              pend.out_id <= sid[idx];
              pend.out_extended <= sext[idx];
              pend.out_payload <= spay[idx];
              pend.out_length <= slen[idx];
              pend.last <= 1'b0;
              if (done_job) begin
                active[idx] <= 1'b0;
                active_jobs <= active_jobs - CW'(1);
              end
            end
            if (!due) begin
              if (is_last_slot) state <= S_FLUSH;
              else idx <= idx + IW'(1);
            end else if (is_last_slot) begin
              state <= S_FLUSH;
            end else idx <= idx + IW'(1);
          end else if (out_free) begin
            if (due || is_last_slot) begin
              // hand over pending; a later due slot exists or end reached
              res <= pend;
              res.last <= !due;
              res_valid <= 1'b1;
              pend_valid <= 1'b0;
              if (!due) state <= S_FLUSH;
            end else idx <= idx + IW'(1);
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            if (pend_valid) begin
              res <= pend;
              res.last <= 1'b1;
              res_valid <= 1'b1;
              pend_valid <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    active_jobs == CW'($countones(active)))
    else $error("job count out of step with active slots");
  assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken while none queued");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("frame held while idle");

endmodule

### hw/rtl/periodic_frame_scheduler.sv
// Top level of the periodic frame scheduler.
// Periodic frame scheduler: a table of SLOT_COUNT periodic transmit jobs. Start, stop
// and stop-all beats each return one status beat: an accepted input beat passes through
// the command queue and, when the back part is idle and the output register is free, is
// answered from the output register. A tick beat walks the slots one per cycle, except
// that a due frame following another, or an output stall, holds the walk. It returns
// one frame beat per due slot in slot order, the final one marked last;
// a tick with nothing due returns nothing. A two-entry command queue lets input beats
// arrive while the slot scan runs. Write min_period only while the block is idle.
module periodic_frame_scheduler #(
  parameter int SLOT_COUNT = pfs_pkg::SlotCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [28:0] frame_id,
  input  logic [63:0] payload,
  input  logic [3:0]  length,
  input  logic [31:0] repeat_count,
  input  logic [31:0] period_ms,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_frame,
  output logic [1:0]  status,
  output logic [28:0] out_id,
  output logic        out_extended,
  output logic [63:0] out_payload,
  output logic [3:0]  out_length,
  output logic        last
);

  logic [31:0]   min_period;
  logic          cmd_valid, cmd_take;
  pfs_pkg::cmd_t cmd;
  pfs_pkg::res_t res;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) min_period <= pfs_pkg::MinPeriodReset;
    else if (cfg_valid && cfg_ready) min_period <= cfg_data;
  end

  pfs_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .action, .frame_id, .payload,
    .length, .repeat_count, .period_ms, .now_ms, .min_period,
    .cmd_valid, .cmd_take, .cmd
  );

  pfs_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd,
    .res_valid(out_valid), .res_stall(out_stall), .res
  );

  assign is_frame = res.is_frame;
  assign status = res.status;
  assign out_id = res.out_id;
  assign out_extended = res.out_extended;
  assign out_payload = res.out_payload;
  assign out_length = res.out_length;
  assign last = res.last;

endmodule

### verif/tb.sv
// Self-checking testbench for the periodic frame scheduler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = pfs_pkg::SlotCountDefault;
  localparam int LIMIT_CYCLES = 400000;

  // One expected or observed result beat
  typedef struct {
    logic        is_frame;
    logic [1:0]  status;
    logic [28:0] id;
    logic        ext;
    logic [63:0] data;
    logic [3:0]  len;
    logic        last;
  } beat_t;

  int errors = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // Scoreboard: keeps its own copy of the job table and the pending beats
  class frame_scoreboard;
    logic        busy[NSLOT];
    logic [28:0] job_id[NSLOT];
    logic        job_ext[NSLOT];
    logic [63:0] job_data[NSLOT];
    logic [3:0]  job_len[NSLOT];
    logic [31:0] job_total[NSLOT];
    logic [31:0] job_sent[NSLOT];
    logic [31:0] job_period[NSLOT];
    logic [31:0] job_time[NSLOT];
    int          jobs;
    logic [31:0] min_period;
    beat_t       pending[$];

    function void clear();
      for (int i = 0; i < NSLOT; i++) busy[i] = 1'b0;
      jobs = 0;
      min_period = pfs_pkg::MinPeriodReset;
    endfunction

    function void push_status(logic [1:0] st);
      beat_t b;
      b = '{1'b0, st, '0, 1'b0, '0, '0, 1'b1};
      pending.push_back(b);
    endfunction

    function bit free_id(logic [28:0] id);
      for (int i = 0; i < NSLOT; i++)
        if (busy[i] && job_id[i] == id) begin
          busy[i] = 1'b0;
          jobs--;
          return 1'b1;
        end
      return 1'b0;
    endfunction

    // Predict the results of one accepted input beat
    function void note_input(logic [1:0] act, logic [28:0] id, logic [63:0] data,
                             logic [3:0] len, logic [31:0] cnt, logic [31:0] per,
                             logic [31:0] now);
      int k;
      int n;
      logic [63:0] m;
      beat_t b;
      case (act)
        pfs_pkg::ACT_START: begin
          if (len == 0 || len > 8) push_status(pfs_pkg::ST_BAD_LEN);
          else if (jobs >= NSLOT) push_status(pfs_pkg::ST_FULL);
          else begin
            void'(free_id(id));
            k = 0;
            while (busy[k]) k++;
            m = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
            job_id[k] = id; job_ext[k] = id > 29'h7FF; job_data[k] = data & m;
            job_len[k] = len; job_total[k] = cnt; job_sent[k] = '0;
            job_period[k] = (per < min_period) ? min_period : per;
            job_time[k] = '0; busy[k] = 1'b1; jobs++;
            push_status(pfs_pkg::ST_OK);
          end
        end
        pfs_pkg::ACT_STOP:
          push_status(free_id(id) ? pfs_pkg::ST_OK : pfs_pkg::ST_NO_JOB);
        pfs_pkg::ACT_STOP_ALL: begin
          for (int i = 0; i < NSLOT; i++) busy[i] = 1'b0;
          jobs = 0;
          push_status(pfs_pkg::ST_OK);
        end
        default: begin
          n = 0;
          for (int i = 0; i < NSLOT; i++) begin
            if (!busy[i]) continue;
            if (job_sent[i] != 0 && (now - job_time[i]) < job_period[i]) continue;
            b = '{1'b1, pfs_pkg::ST_OK, job_id[i], job_ext[i], job_data[i], job_len[i],
                  1'b0};
            pending.push_back(b);
            n++;
            if (job_sent[i] != '1) job_sent[i]++;
            job_time[i] = now;
            if (job_total[i] != 0 && job_sent[i] >= job_total[i]) begin
              busy[i] = 1'b0;
              jobs--;
            end
          end
          if (n > 0) pending[pending.size() - 1].last = 1'b1;
        end
      endcase
    endfunction

    // Compare an observed beat against the oldest expectation
    task check_result(beat_t got);
      beat_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected beat id=%h", got.id));
        return;
      end
      e = pending.pop_front();
      if (got.is_frame !== e.is_frame) report_mismatch("is_frame");
      if (got.status !== e.status)
        report_mismatch($sformatf("status got %0d exp %0d", got.status, e.status));
      if (got.id !== e.id) report_mismatch($sformatf("out_id got %h exp %h", got.id, e.id));
      if (got.ext !== e.ext) report_mismatch("out_extended");
      if (got.data !== e.data) report_mismatch("out_payload");
      if (got.len !== e.len) report_mismatch("out_length");
      if (got.last !== e.last) report_mismatch("last");
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] action = 0;
  logic [28:0] frame_id = 0;
  logic [63:0] payload = 0;
  logic [3:0] length = 0;
  logic [31:0] repeat_count = 0;
  logic [31:0] period_ms = 0;
  logic [31:0] now_ms = 0;
  logic out_valid;
  logic out_stall = 0;
  logic is_frame;
  logic [1:0] status;
  logic [28:0] out_id;
  logic out_extended;
  logic [63:0] out_payload;
  logic [3:0] out_length;
  logic last;

  periodic_frame_scheduler uut (.*);

  always #5 clk = ~clk;

  frame_scoreboard sb = new();
  int cycle = 0;
  bit calm = 0;          // no idling stretch
  logic [31:0] clock_ms = 0;
  logic [28:0] id_pool[6] = '{29'h0, 29'h7FF, 29'h800, 29'h1FFFFFFF, 29'h123, 29'h5A5A5};

  // Cycle limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stall, check accepted beats
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{is_frame, status, out_id, out_extended, out_payload,
                        out_length, last});
    out_stall <= rst ? 1'b0 : (!calm && $urandom_range(99) < 19);
  end

  // Send one input beat, with a random gap first; valid stays up after the
  // accepting edge until the next beat, a gap or a drain replaces it
  task automatic send_beat(input logic [1:0] a, input logic [28:0] id,
                           input logic [63:0] d, input logic [3:0] l,
                           input logic [31:0] c, input logic [31:0] p,
                           input logic [31:0] t);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; action <= a; frame_id <= id; payload <= d; length <= l;
    repeat_count <= c; period_ms <= p; now_ms <= t;
    do @(posedge clk); while (in_stall);
    sb.note_input(a, id, d, l, c, p, t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_min_period(input logic [31:0] v);
    drain();
    cfg_valid <= 1; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.min_period = v;
    cfg_valid <= 0;
  endtask

  task automatic tick(input logic [31:0] step);
    clock_ms += step;
    send_beat(pfs_pkg::ACT_TICK, 29'($urandom), {$urandom, $urandom}, 4'($urandom),
              $urandom, $urandom, clock_ms);
  endtask

  // Mostly well-formed starts, ticks, stops with random content
  task automatic random_phase(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 30)
        send_beat(pfs_pkg::ACT_START,
                  ($urandom_range(3) == 0) ? 29'($urandom) : id_pool[$urandom_range(5)],
                  {$urandom, $urandom},
                  ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8)),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4),
                  ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 30), $urandom);
      else if (r < 40)
        send_beat(pfs_pkg::ACT_STOP,
                  ($urandom_range(3) == 0) ? 29'($urandom) : id_pool[$urandom_range(5)],
                  {$urandom, $urandom}, 4'($urandom), $urandom, $urandom, $urandom);
      else if (r < 43)
        send_beat(pfs_pkg::ACT_STOP_ALL, 29'($urandom), {$urandom, $urandom},
                  4'($urandom), $urandom, $urandom, $urandom);
      else if (r < 46) tick($urandom);
      else tick($urandom_range(0, 25));
    end
  endtask

  initial begin
    sb.clear();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: length edges, extremes, replacement, full table, count of one
    send_beat(pfs_pkg::ACT_START, 29'h0, '1, 4'd0, '0, '0, '0);
    send_beat(pfs_pkg::ACT_START, 29'h0, '1, 4'd9, '0, '0, '0);
    send_beat(pfs_pkg::ACT_START, 29'h0, '1, 4'd15, '0, '0, '0);
    send_beat(pfs_pkg::ACT_START, 29'h7FF, '1, 4'd1, 32'd1, 32'd0, '0);
    send_beat(pfs_pkg::ACT_START, 29'h800, '1, 4'd8, 32'hFFFFFFFF, 32'hFFFFFFFF, '0);
    send_beat(pfs_pkg::ACT_START, 29'h1FFFFFFF, 64'h0123456789ABCDEF, 4'd3, '0, 32'd5,
              '0);
    send_beat(pfs_pkg::ACT_START, 29'h1FFFFFFF, 64'hFEDCBA9876543210, 4'd7, 32'd2, 32'd20,
              '0);
    tick(32'd0);
    tick(32'd5);
    tick(32'd10);
    send_beat(pfs_pkg::ACT_STOP, 29'h7FF, '0, 4'd0, '0, '0, '0);
    send_beat(pfs_pkg::ACT_STOP, 29'h800, '0, 4'd0, '0, '0, '0);
    for (int i = 0; i < 9; i++)
      send_beat(pfs_pkg::ACT_START, 29'(i + 1), {$urandom, $urandom}, 4'd8, '0, '0, '0);
    send_beat(pfs_pkg::ACT_START, 29'd1, '1, 4'd2, '0, '0, '0);
    tick(32'hFFFFFFF0);
    tick(32'h20);
    send_beat(pfs_pkg::ACT_STOP_ALL, '1, '1, '1, '1, '1, '1);
    tick(32'd100);

    // Settings of the minimum period, extremes included
    write_min_period(32'd0);
    random_phase(70);
    calm = 1;
    write_min_period(32'hFFFFFFFF);
    random_phase(40);
    calm = 0;
    write_min_period(32'd7);
    random_phase(80);
    write_min_period(pfs_pkg::MinPeriodReset);
    random_phase(80);

    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
